// ===== rtl/assert_macros.svh =====
// assertion macros for the ring list rtl
// expects clk_i and rst_ni in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define RRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rrl_pkg.sv =====
// shared types and constants for the round-robin ring list
// no dependencies
package rrl_pkg;

  localparam int unsigned Depth   = 16;
  localparam int unsigned HandleW = 32;
  localparam int unsigned IdxW    = $clog2(Depth);
  localparam int unsigned CntW    = $clog2(Depth + 1);

  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [CntW-1:0]    cnt_t;
  typedef logic [HandleW-1:0] handle_t;

  localparam cnt_t DepthCnt = cnt_t'(Depth);

  typedef enum logic [1:0] {
    CmdAdd    = 2'd0,
    CmdRemove = 2'd1,
    CmdNext   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StMiss = 2'd1,
    StFull = 2'd2
  } status_e;

  // one read address for all three stores, one write port per store
  typedef struct packed {
    idx_t    rd_addr;
    logic    h_we;
    idx_t    h_addr;
    handle_t h_data;
    logic    n_we;
    idx_t    n_addr;
    idx_t    n_data;
    logic    p_we;
    idx_t    p_addr;
    idx_t    p_data;
  } store_req_t;

  typedef struct packed {
    handle_t handle;
    idx_t    next;
    idx_t    prev;
  } store_rsp_t;

  typedef struct packed {
    logic    valid;
    status_e status;
    handle_t handle;
    logic    empty;
  } res_t;

endpackage

// ===== rtl/rrl_slot_store.sv =====
// slot memories: handle, next link and prev link per slot
// depends on rrl_pkg
module rrl_slot_store (
  input  logic               clk_i,
  input  rrl_pkg::store_req_t req_i,
  output rrl_pkg::store_rsp_t rsp_o
);
  import rrl_pkg::*;

  handle_t    handle_mem [Depth];
  idx_t       next_mem   [Depth];
  idx_t       prev_mem   [Depth];
  store_rsp_t rsp_q;

  always_ff @(posedge clk_i) begin
    if (req_i.h_we) begin
      handle_mem[req_i.h_addr] <= req_i.h_data;
    end
    if (req_i.n_we) begin
      next_mem[req_i.n_addr] <= req_i.n_data;
    end
    if (req_i.p_we) begin
      prev_mem[req_i.p_addr] <= req_i.p_data;
    end
  end

  // registered read, one shared address
  always_ff @(posedge clk_i) begin
    rsp_q.handle <= handle_mem[req_i.rd_addr];
    rsp_q.next   <= next_mem[req_i.rd_addr];
    rsp_q.prev   <= prev_mem[req_i.rd_addr];
  end

  assign rsp_o = rsp_q;

endmodule

// ===== rtl/rrl_ctrl.sv =====
// command sequencer: slot bookkeeping, link updates and the search compare
// depends on rrl_pkg, rrl_slot_store timing and assert_macros.svh
module rrl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          command_i,
  input  rrl_pkg::handle_t    handle_i,
  output logic                in_stall_o,
  input  rrl_pkg::store_rsp_t rsp_i,
  output rrl_pkg::store_req_t req_o,
  input  logic                out_free_i,
  output rrl_pkg::res_t       res_o
);
  import rrl_pkg::*;

  typedef enum logic [5:0] {
    SIdle     = 6'b000001,
    SAddLink  = 6'b000010,
    SAddLink2 = 6'b000100,
    SRmCmp    = 6'b001000,
    SNextRd   = 6'b010000,
    SDone     = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  idx_t               cur_q, cur_d;
  cnt_t               cnt_q, cnt_d;
  logic [Depth-1:0]   used_q, used_d;
  idx_t               slot_q, slot_d;
  idx_t               ptr_q, ptr_d;
  cnt_t               seen_q, seen_d;
  handle_t            key_q, key_d;
  status_e            status_q, status_d;
  handle_t            hout_q, hout_d;
  idx_t               free_slot;
  logic               hit;
  store_req_t         req;

  // lowest free slot
  function automatic idx_t first_free(input logic [Depth-1:0] used);
    idx_t r;
    logic found;
    r = '0;
    found = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      if (!found && !used[i]) begin
        r = idx_t'(i);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  assign free_slot = first_free(used_q);
  assign hit       = (rsp_i.handle == key_q);

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    cnt_d    = cnt_q;
    used_d   = used_q;
    slot_d   = slot_q;
    ptr_d    = ptr_q;
    seen_d   = seen_q;
    key_d    = key_q;
    status_d = status_q;
    hout_d   = hout_q;
    req         = '0;
    req.rd_addr = cur_q;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          key_d    = handle_i;
          status_d = StMiss;
          hout_d   = '0;
          state_d  = SDone;
          case (cmd_e'(command_i))
            CmdAdd: begin
              if (cnt_q == DepthCnt) begin
                status_d = StFull;
              end else begin
                slot_d     = free_slot;
                req.h_we   = 1'b1;
                req.h_addr = free_slot;
                req.h_data = handle_i;
                if (cnt_q == '0) begin
                  req.n_we   = 1'b1;
                  req.n_addr = free_slot;
                  req.n_data = free_slot;
                  req.p_we   = 1'b1;
                  req.p_addr = free_slot;
                  req.p_data = free_slot;
                  cur_d      = free_slot;
                  used_d[free_slot] = 1'b1;
                  cnt_d      = cnt_q + 1'b1;
                  status_d   = StOk;
                end else begin
                  state_d = SAddLink;
                end
              end
            end
            CmdRemove: begin
              if (cnt_q != '0) begin
                ptr_d   = cur_q;
                seen_d  = '0;
                state_d = SRmCmp;
              end
            end
            CmdNext: begin
              if (cnt_q != '0) begin
                state_d = SNextRd;
              end
            end
            default: ;
          endcase
        end
      end
      SAddLink: begin
        // rsp prev is the tail behind current
        req.n_we   = 1'b1;
        req.n_addr = rsp_i.prev;
        req.n_data = slot_q;
        req.p_we   = 1'b1;
        req.p_addr = slot_q;
        req.p_data = rsp_i.prev;
        state_d    = SAddLink2;
      end
      SAddLink2: begin
        req.n_we   = 1'b1;
        req.n_addr = slot_q;
        req.n_data = cur_q;
        req.p_we   = 1'b1;
        req.p_addr = cur_q;
        req.p_data = slot_q;
        used_d[slot_q] = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        status_d   = StOk;
        state_d    = SDone;
      end
      SRmCmp: begin
        if (hit) begin
          if (cnt_q == cnt_t'(1)) begin
            cur_d = '0;
          end else begin
            req.n_we   = 1'b1;
            req.n_addr = rsp_i.prev;
            req.n_data = rsp_i.next;
            req.p_we   = 1'b1;
            req.p_addr = rsp_i.next;
            req.p_data = rsp_i.prev;
            if (cur_q == ptr_q) begin
              cur_d = rsp_i.next;
            end
          end
          used_d[ptr_q] = 1'b0;
          cnt_d    = cnt_q - 1'b1;
          status_d = StOk;
          state_d  = SDone;
        end else if (cnt_t'(seen_q + 1'b1) == cnt_q) begin
          state_d = SDone;
        end else begin
          // follow the link, read the next slot straight away
          ptr_d       = rsp_i.next;
          seen_d      = seen_q + 1'b1;
          req.rd_addr = rsp_i.next;
        end
      end
      SNextRd: begin
        hout_d   = rsp_i.handle;
        cur_d    = rsp_i.next;
        status_d = StOk;
        state_d  = SDone;
      end
      SDone: begin
        if (out_free_i) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cur_q   <= '0;
      cnt_q   <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      cnt_q   <= cnt_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    ptr_q    <= ptr_d;
    seen_q   <= seen_d;
    key_q    <= key_d;
    status_q <= status_d;
    hout_q   <= hout_d;
  end

  assign req_o         = req;
  assign in_stall_o    = (state_q != SIdle);
  assign res_o.valid   = (state_q == SDone);
  assign res_o.status  = status_q;
  assign res_o.handle  = hout_q;
  assign res_o.empty   = (cnt_q == '0);

  `include "assert_macros.svh"

  `RRL_ASSERT(a_cnt_bound, (cnt_q <= DepthCnt), "entry count above depth")
  `RRL_ASSERT(a_used_cnt, ($countones(used_q) == int'(cnt_q)), "used bits disagree with count")
  `RRL_ASSERT(a_add_slot_free, ((state_q == SAddLink) |-> !used_q[slot_q]), "add slot in use")
  `RRL_ASSERT(a_search_bound, ((state_q == SRmCmp) |-> (seen_q < cnt_q)), "search overran ring")
  `RRL_ASSERT_NEXT(a_add_seq, (state_q == SAddLink), (state_q == SAddLink2), "add link broken")

endmodule

// ===== rtl/round_robin_ring_list_core.sv =====
// top level of the round-robin ring list
// depends on rrl_pkg, rrl_slot_store and rrl_ctrl
//
// ring of up to 16 32-bit handles kept as a circular doubly linked list in
// three small slot memories (handle, next, prev) with registered reads.
// commands: add links the handle just behind current (tail), status full when
// all slots are taken; remove walks forward from current and unlinks the first
// equal handle, status not-found when missing or empty; next returns the
// current handle and advances. one command is worked at a time and the input
// is stalled meanwhile. a remove walk visits no slot on an empty ring, else
// 1..16 slots; the shared compare checks one slot per cycle while following
// next links through the single memory read port. a finished result sits in
// an output register so a new command can be taken while it waits to be
// picked up.
module round_robin_ring_list_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            command_i,
  input  logic [31:0]           handle_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [31:0]           handle_out_o,
  output logic                  is_empty_o
);
  import rrl_pkg::*;

  store_req_t store_req;
  store_rsp_t store_rsp;
  res_t       res;
  logic       out_free;

  // output register state
  logic       out_valid_q, out_valid_d;
  logic [1:0] status_q;
  handle_t    handle_q;
  logic       empty_q;

  // output slot can take a new result when empty or being drained this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  rrl_slot_store u_store (
    .clk_i (clk_i),
    .req_i (store_req),
    .rsp_o (store_rsp)
  );

  rrl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .handle_i   (handle_i),
    .in_stall_o (in_stall_o),
    .rsp_i      (store_rsp),
    .req_o      (store_req),
    .out_free_i (out_free),
    .res_o      (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid && out_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded on the cycle the sequencer hands it over
  always_ff @(posedge clk_i) begin
    if (res.valid && out_free) begin
      status_q <= res.status;
      handle_q <= res.handle;
      empty_q  <= res.empty;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign handle_out_o = handle_q;
  assign is_empty_o   = empty_q;

endmodule
